// ===== sv/peak_to_peak_sound_level_meter_defines.svh =====
// Assertion macros used by the sound level meter checker.
`ifndef PEAK_TO_PEAK_SOUND_LEVEL_METER_DEFINES_SVH
`define PEAK_TO_PEAK_SOUND_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define P2P_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define P2P_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/p2p_pkg.sv =====
// Package: widths, register indexes, divider status and the dB curve table.
package p2p_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int DB_W            = 28;
	localparam int LEQ_W           = 36;
	localparam int SUM_W           = 37;
	localparam int FRAC_BITS       = 8;
	localparam int DIV_W           = SUM_W + FRAC_BITS;
	localparam int WS_W            = 16;
	localparam int WPA_W           = 8;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 16;
	localparam int ROM_IDX_W       = 8;
	localparam int ROM_DEPTH       = 1 << ROM_IDX_W;
	localparam int CURVE_MAX_DB    = 66;

	localparam logic [WS_W-1:0]  WS_RESET  = 16'd1000;
	localparam logic [WPA_W-1:0] WPA_RESET = 8'd120;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_PER_AVERAGE = 8'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef logic signed [DB_W-1:0] curve_rom_t [ROM_DEPTH];

	// log2 in Q32: normalize to [1,2) in Q30, then one fraction bit per squaring
	function automatic logic [63:0] log2_q32(logic [63:0] n);
		logic [63:0] t;
		logic [63:0] m;
		logic [63:0] frac;
		int unsigned k;
		int i;
		k = 0;
		t = n;
		frac = '0;
		for (i = 0; i < 64; i++) begin
			if (t > 64'd1) begin
				t = t >> 1;
				k = k + 1;
			end
		end
		m = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
		for (i = 0; i < 32; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		return (64'(k) << 32) | frac;
	endfunction

	// Fitted logistic curve, integer dB, truncated toward zero
	function automatic logic signed [DB_W-1:0] curve_db(int unsigned p);
		logic signed [63:0] l;
		logic signed [63:0] e;
		logic signed [63:0] kk;
		logic signed [63:0] v;
		logic [63:0] mag;
		logic [63:0] f;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] x;
		logic [63:0] d;
		logic [63:0] r;
		logic [63:0] q;
		logic [63:0] dbit;
		logic [63:0] span;
		int n;
		int i;
		x = '0;
		span = 64'd8086782636645;
		if (p != 0) begin
			l = signed'(log2_q32(64'(p))) - signed'(log2_q32(64'd1088287))
				+ signed'(log2_q32(64'd100000));
			e = (l * 64'sd8387665) / 64'sd1000000;
			if (e >= (64'sd30 <<< 32)) begin
				return DB_W'(CURVE_MAX_DB);
			end
			if (e >= 0) begin
				kk = e >>> 32;
				f = {32'd0, e[31:0]};
			end else begin
				mag = unsigned'(-e);
				kk = -signed'((mag + 64'd4294967295) >> 32);
				f = unsigned'(e - (kk <<< 32));
			end
			t = (f * 64'd2977044472) >> 32;
			sum = 64'd1 << 32;
			term = 64'd1 << 32;
			for (n = 1; n <= 24; n++) begin
				term = ((term * t) >> 32) / 64'(n);
				sum = sum + term;
			end
			if (kk >= 0) begin
				x = sum << kk;
			end else if (-kk >= 63) begin
				x = '0;
			end else begin
				x = sum >> (-kk);
			end
		end
		d = (64'd1 << 32) + x;
		r = '0;
		q = '0;
		for (i = 74; i >= 0; i--) begin
			dbit = (i >= 32) ? ((span >> (i - 32)) & 64'd1) : 64'd0;
			r = (r << 1) | dbit;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		v = 64'sd6636645 - signed'(q);
		v = v / 64'sd100000;
		return v[DB_W-1:0];
	endfunction

	function automatic curve_rom_t build_curve_rom();
		curve_rom_t rom;
		int i;
		for (i = 0; i < ROM_DEPTH; i++) begin
			rom[i] = curve_db(i);
		end
		return rom;
	endfunction

	// Above this range the curve sits at its top value
	localparam curve_rom_t CURVE_ROM = build_curve_rom();

endpackage

// ===== sv/p2p_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the Leq mean.
module p2p_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [p2p_pkg::DIV_W-1:0]  dividend,
	input  logic [p2p_pkg::WPA_W-1:0]  divisor,
	output p2p_pkg::div_status_t       status,
	output logic [p2p_pkg::DIV_W-1:0]  quotient
);
	import p2p_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [WPA_W-1:0] rem_q;
	logic [WPA_W-1:0] divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WPA_W:0]   rem_sh;
	logic             fits;
	logic [WPA_W:0]   rem_diff;

	always_comb begin
		rem_sh   = {rem_q, dvd_q[DIV_W-1]};
		fits     = rem_sh >= {1'b0, divisor_q};
		rem_diff = rem_sh - {1'b0, divisor_q};
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
			rem_q <= fits ? rem_diff[WPA_W-1:0] : rem_sh[WPA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dvd_q;

endmodule

// ===== sv/peak_to_peak_sound_level_meter.sv =====
// Peak-to-peak sound level meter: windowed min/max, dB curve lookup, Leq mean.
//
// Input channel (in_valid/in_ready, sample): one ADC word per handshake. A
// full-scale word counts toward the window but leaves min/max alone.
// Output channel (out_valid/out_ready): one word per finished window with
// window_db; every windows_per_average-th word also carries leq_q8 (Q.8
// mean) with leq_valid high, otherwise leq_q8 is 0.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
// window_samples, index 1 windows_per_average; other indexes are dropped.
// Write it only while the block is idle; cfg_ready is always high.
// Sequence: a word that does not close a window leaves the block idle. A
// closing word goes through accept, table lookup, accumulate and load into
// the output register, with a divide before the load when it also closes
// an averaging period: the restoring divider retires one quotient bit of
// the 45-bit Q.8 dividend per cycle. in_ready is low during that sequence.
// A finished word waits in the output register; samples keep coming in
// while it stalls, and only the next window end waits for out_ready.
// Reset: window_samples 1000, windows_per_average 120, counters, sum and
// min/max cleared, output register empty.
module peak_to_peak_sound_level_meter #(
	parameter int SAMPLE_BITS = p2p_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [SAMPLE_BITS-1:0]             sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [p2p_pkg::DB_W-1:0]    window_db,
	output logic signed [p2p_pkg::LEQ_W-1:0]   leq_q8,
	output logic                               leq_valid,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [p2p_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [p2p_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import p2p_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOKUP = 5'b00010,
		S_ACCUM  = 5'b00100,
		S_DIV    = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [WS_W-1:0]         ws_q;
	logic [WPA_W-1:0]        wpa_q;
	logic [SAMPLE_BITS-1:0]  min_q;
	logic [SAMPLE_BITS-1:0]  max_q;
	logic [WS_W-1:0]         seen_q;
	logic [WPA_W-1:0]        wseen_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SAMPLE_BITS-1:0]  p2p_q;
	logic signed [DB_W-1:0]  db_q;
	logic                    neg_q;
	logic signed [LEQ_W-1:0] leq_q;
	logic                    leq_flag_q;

	logic                    out_valid_q;
	logic signed [DB_W-1:0]  window_db_q;
	logic signed [LEQ_W-1:0] leq_q8_q;
	logic                    leq_valid_q;

	logic                    in_acc;
	logic                    spurious;
	logic [SAMPLE_BITS-1:0]  min_n;
	logic [SAMPLE_BITS-1:0]  max_n;
	logic [SAMPLE_BITS-1:0]  p2p_n;
	logic [WS_W:0]           count;
	logic                    win_end;
	logic signed [DB_W-1:0]  db_n;
	logic signed [SUM_W-1:0] sum_n;
	logic [WPA_W:0]          wcount;
	logic                    avg_end;
	logic [SUM_W-1:0]        sum_mag;
	logic                    div_start;
	logic [DIV_W-1:0]        div_dividend;
	logic [DIV_W-1:0]        quotient;
	logic [DIV_W-1:0]        quot_signed;
	div_status_t             div_status;
	logic                    out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		spurious = &sample;
		max_n    = (!spurious && (sample > max_q)) ? sample : max_q;
		min_n    = (!spurious && (sample < min_q)) ? sample : min_q;
		// empty window leaves max below min
		p2p_n    = (max_n >= min_n) ? (max_n - min_n) : '0;
		count    = {1'b0, seen_q} + 1'b1;
		win_end  = count >= {1'b0, ws_q};
	end

	always_comb begin
		db_n = ((p2p_q >> ROM_IDX_W) != '0) ? DB_W'(CURVE_MAX_DB)
			: CURVE_ROM[p2p_q[ROM_IDX_W-1:0]];
	end

	always_comb begin
		sum_n        = sum_q + {{(SUM_W-DB_W){db_q[DB_W-1]}}, db_q};
		wcount       = {1'b0, wseen_q} + 1'b1;
		avg_end      = wcount >= {1'b0, wpa_q};
		sum_mag      = sum_n[SUM_W-1] ? (~sum_n + 1'b1) : sum_n;
		div_dividend = {sum_mag, {FRAC_BITS{1'b0}}};
		div_start    = (state_q == S_ACCUM) && avg_end;
		quot_signed  = neg_q ? (~quotient + 1'b1) : quotient;
	end

	p2p_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (wcount[WPA_W-1:0]),
		.status   (div_status),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q  <= WS_RESET;
			wpa_q <= WPA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_SAMPLES:      ws_q  <= cfg_data[WS_W-1:0];
				REG_WINDOWS_PER_AVERAGE: wpa_q <= cfg_data[WPA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_q       <= '1;
			max_q       <= '0;
			seen_q      <= '0;
			wseen_q     <= '0;
			sum_q       <= '0;
			leq_flag_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_EMIT the emit arm decides out_valid_q
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (win_end) begin
							min_q   <= '1;
							max_q   <= '0;
							seen_q  <= '0;
							state_q <= S_LOOKUP;
						end else begin
							min_q  <= min_n;
							max_q  <= max_n;
							seen_q <= count[WS_W-1:0];
						end
					end
				end
				S_LOOKUP: begin
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					if (avg_end) begin
						sum_q   <= '0;
						wseen_q <= '0;
						state_q <= S_DIV;
					end else begin
						sum_q      <= sum_n;
						wseen_q    <= wcount[WPA_W-1:0];
						leq_flag_q <= 1'b0;
						state_q    <= S_EMIT;
					end
				end
				S_DIV: begin
					if (div_status.done) begin
						leq_flag_q <= 1'b1;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath words, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc && win_end) begin
			p2p_q <= p2p_n;
		end
		if (state_q == S_LOOKUP) begin
			db_q <= db_n;
		end
		if (state_q == S_ACCUM) begin
			neg_q <= sum_n[SUM_W-1];
			if (!avg_end) begin
				leq_q <= '0;
			end
		end
		if (state_q == S_DIV && div_status.done) begin
			leq_q <= quot_signed[LEQ_W-1:0];
		end
		if (state_q == S_EMIT && out_free) begin
			window_db_q <= db_q;
			leq_q8_q    <= leq_q;
			leq_valid_q <= leq_flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign window_db = window_db_q;
	assign leq_q8    = leq_q8_q;
	assign leq_valid = leq_valid_q;

endmodule

// ===== sv/p2p_checker.sv =====
// Port-level checks for the sound level meter, bound to the top level.
`include "peak_to_peak_sound_level_meter_defines.svh"

module p2p_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic signed [p2p_pkg::DB_W-1:0]  window_db,
	input  logic signed [p2p_pkg::LEQ_W-1:0] leq_q8,
	input  logic                             leq_valid
);
	import p2p_pkg::*;

	// stalled word holds
	`P2P_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(window_db) && $stable(leq_q8) && $stable(leq_valid), "output word changed while stalled")

	`P2P_ASSERT_IMP(a_db_top, out_valid, window_db <= CURVE_MAX_DB, "window level above curve top")

	`P2P_ASSERT_IMP(a_leq_zero, out_valid && !leq_valid, leq_q8 == '0, "leq_q8 nonzero without leq_valid")

	`P2P_ASSERT_IMP(a_leq_top, out_valid && leq_valid, leq_q8 <= (CURVE_MAX_DB * (1 << FRAC_BITS)), "Leq mean above curve top")

endmodule

bind peak_to_peak_sound_level_meter p2p_checker u_p2p_checker (.*);
